/* rtl/csx_pkg.sv */
package csx_pkg;

    localparam int DATA_W   = 64;
    localparam int START_W  = 6;
    localparam int SIZE_W   = 5;
    localparam int FACTOR_W = 32;
    localparam int FIX_W    = 48;
    localparam int PHYS_W   = 64;
    localparam int WIN_W    = 24;
    localparam int RAW_W    = WIN_W + 1;
    localparam int PROD_W   = RAW_W + FACTOR_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int DIST_W   = 7;

    localparam logic [SIZE_W-1:0] SIGNED_SIZE_BYTE = SIZE_W'(8);
    localparam logic [SIZE_W-1:0] SIGNED_SIZE_WORD = SIZE_W'(16);

    // Distance of the field's LSB below the first byte's bit 0
    localparam logic signed [DIST_W-1:0] DIST_TWO_BYTES   = -DIST_W'(8);
    localparam logic signed [DIST_W-1:0] DIST_THREE_BYTES = -DIST_W'(16);
    localparam logic signed [DIST_W-1:0] WIN_BIAS         = DIST_W'(16);

    typedef struct packed {
        logic [DATA_W-1:0]          frame_data;
        logic [START_W-1:0]         msb_pos;
        logic [SIZE_W-1:0]          field_len;
        logic                       sign_mode;
        logic signed [FACTOR_W-1:0] scale_factor;
        logic signed [FIX_W-1:0]    phys_offset;
        logic signed [FIX_W-1:0]    lower_limit;
        logic signed [FIX_W-1:0]    upper_limit;
    } t_req;

    typedef struct packed {
        logic signed [RAW_W-1:0]    raw;
        logic signed [FACTOR_W-1:0] factor;
        logic signed [FIX_W-1:0]    offset;
        logic signed [FIX_W-1:0]    lo;
        logic signed [FIX_W-1:0]    hi;
        logic                       err;
    } t_raw;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic signed [FIX_W-1:0]  offset;
        logic signed [FIX_W-1:0]  lo;
        logic signed [FIX_W-1:0]  hi;
        logic                     err;
    } t_prod;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic signed [FIX_W-1:0] lo;
        logic signed [FIX_W-1:0] hi;
        logic                    err;
    } t_sum;

    typedef struct packed {
        logic signed [PHYS_W-1:0] phys_value;
        logic                     range_error;
    } t_res;

endpackage

/* rtl/csx_if.sv */
interface csx_in_if;
    logic                                        valid;
    logic                                        ready;
    logic [csx_pkg::DATA_W-1:0]                  frame_data;
    logic [csx_pkg::START_W-1:0]                 msb_pos;
    logic [csx_pkg::SIZE_W-1:0]                  field_len;
    logic                                        sign_mode;
    logic signed [csx_pkg::FACTOR_W-1:0]         scale_factor;
    logic signed [csx_pkg::FIX_W-1:0]            phys_offset;
    logic signed [csx_pkg::FIX_W-1:0]            lower_limit;
    logic signed [csx_pkg::FIX_W-1:0]            upper_limit;

    modport source (
        output valid, frame_data, msb_pos, field_len, sign_mode,
               scale_factor, phys_offset, lower_limit, upper_limit,
        input  ready
    );
    modport sink (
        input  valid, frame_data, msb_pos, field_len, sign_mode,
               scale_factor, phys_offset, lower_limit, upper_limit,
        output ready
    );
endinterface

interface csx_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [csx_pkg::PHYS_W-1:0] phys_value;
    logic                              range_error;

    modport source (
        output valid, phys_value, range_error,
        input  ready
    );
    modport sink (
        input  valid, phys_value, range_error,
        output ready
    );
endinterface

/* rtl/csx_extract.sv */
module csx_extract (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  csx_pkg::t_req   i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output csx_pkg::t_raw   o_raw
);

    logic                                    r_valid;
    csx_pkg::t_raw                           r_raw;
    csx_pkg::t_raw                           n_raw;
    logic [2:0]                              bit_pos;
    logic [2:0]                              byte_ix;
    logic signed [csx_pkg::DIST_W-1:0]       lsb_gap;
    logic signed [csx_pkg::DIST_W-1:0]       win_shift;
    logic [1:0]                              extra_bytes;
    logic [3:0]                              last_byte;
    logic                                    need_four;
    logic [csx_pkg::DATA_W-1:0]              aligned;
    logic [csx_pkg::WIN_W-1:0]               window;
    logic [csx_pkg::WIN_W-1:0]               mask;
    logic [csx_pkg::WIN_W-1:0]               field;
    logic                                    sext_byte;
    logic                                    sext_word;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_raw   = r_raw;

    always_comb begin
        bit_pos = i_req.msb_pos[2:0];
        byte_ix = i_req.msb_pos[5:3];
        lsb_gap = signed'({4'b0000, bit_pos}) + csx_pkg::DIST_W'(1)
                - signed'({2'b00, i_req.field_len});
        need_four = lsb_gap < csx_pkg::DIST_THREE_BYTES;
        if (lsb_gap >= 0) begin
            extra_bytes = 2'd0;
        end else if (lsb_gap >= csx_pkg::DIST_TWO_BYTES) begin
            extra_bytes = 2'd1;
        end else begin
            extra_bytes = 2'd2;
        end
        last_byte = {1'b0, byte_ix} + {2'b00, extra_bytes};

        // Three bytes from the field's first byte, zeros past byte 7
        aligned   = i_req.frame_data << {byte_ix, 3'b000};
        window    = aligned[csx_pkg::DATA_W-1 -: csx_pkg::WIN_W];
        win_shift = lsb_gap + csx_pkg::WIN_BIAS;
        mask      = ~({csx_pkg::WIN_W{1'b1}} << i_req.field_len);
        field     = (window >> win_shift[4:0]) & mask;

        sext_byte = i_req.sign_mode && (i_req.field_len == csx_pkg::SIGNED_SIZE_BYTE)
                    && field[7];
        sext_word = i_req.sign_mode && (i_req.field_len == csx_pkg::SIGNED_SIZE_WORD)
                    && field[15];

        if (sext_byte) begin
            n_raw.raw = {{(csx_pkg::RAW_W-8){1'b1}}, field[7:0]};
        end else if (sext_word) begin
            n_raw.raw = {{(csx_pkg::RAW_W-16){1'b1}}, field[15:0]};
        end else begin
            n_raw.raw = {1'b0, field};
        end
        n_raw.factor = i_req.scale_factor;
        n_raw.offset = i_req.phys_offset;
        n_raw.lo     = i_req.lower_limit;
        n_raw.hi     = i_req.upper_limit;
        n_raw.err    = need_four || last_byte[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_raw <= n_raw;
        end
    end

endmodule

/* rtl/csx_mul.sv */
module csx_mul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  csx_pkg::t_raw   i_raw,
    output logic            o_valid,
    input  logic            i_ready,
    output csx_pkg::t_prod  o_prod
);

    logic                                r_valid;
    csx_pkg::t_prod                      r_prod;
    csx_pkg::t_prod                      n_prod;
    logic signed [csx_pkg::PROD_W-1:0]   raw_ext;
    logic signed [csx_pkg::PROD_W-1:0]   factor_ext;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_prod  = r_prod;

    always_comb begin
        raw_ext     = csx_pkg::PROD_W'(i_raw.raw);
        factor_ext  = csx_pkg::PROD_W'(i_raw.factor);
        n_prod.prod   = raw_ext * factor_ext;
        n_prod.offset = i_raw.offset;
        n_prod.lo     = i_raw.lo;
        n_prod.hi     = i_raw.hi;
        n_prod.err    = i_raw.err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
        end
    end

endmodule

/* rtl/csx_add.sv */
module csx_add (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  csx_pkg::t_prod  i_prod,
    output logic            o_valid,
    input  logic            i_ready,
    output csx_pkg::t_sum   o_sum
);

    logic                               r_valid;
    csx_pkg::t_sum                      r_sum;
    csx_pkg::t_sum                      n_sum;
    logic signed [csx_pkg::SUM_W-1:0]   prod_ext;
    logic signed [csx_pkg::SUM_W-1:0]   offset_ext;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_sum   = r_sum;

    always_comb begin
        prod_ext   = csx_pkg::SUM_W'(i_prod.prod);
        offset_ext = csx_pkg::SUM_W'(i_prod.offset);
        n_sum.sum  = prod_ext + offset_ext;
        n_sum.lo   = i_prod.lo;
        n_sum.hi   = i_prod.hi;
        n_sum.err  = i_prod.err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sum <= n_sum;
        end
    end

endmodule

/* rtl/csx_clamp.sv */
module csx_clamp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  csx_pkg::t_sum   i_sum,
    output logic            o_valid,
    input  logic            i_ready,
    output csx_pkg::t_res   o_res
);

    logic                               r_valid;
    csx_pkg::t_res                      r_res;
    csx_pkg::t_res                      n_res;
    logic signed [csx_pkg::SUM_W-1:0]   lo_ext;
    logic signed [csx_pkg::SUM_W-1:0]   hi_ext;
    logic signed [csx_pkg::SUM_W-1:0]   capped;
    logic signed [csx_pkg::SUM_W-1:0]   bounded;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        lo_ext = csx_pkg::SUM_W'(i_sum.lo);
        hi_ext = csx_pkg::SUM_W'(i_sum.hi);
        // Upper limit first, lower limit last so it wins on crossed limits
        capped  = (i_sum.sum > hi_ext) ? hi_ext : i_sum.sum;
        bounded = (capped < lo_ext) ? lo_ext : capped;
        if (i_sum.err) begin
            n_res.phys_value = '0;
        end else begin
            n_res.phys_value = csx_pkg::PHYS_W'(bounded);
        end
        n_res.range_error = i_sum.err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= n_res;
        end
    end

endmodule

/* rtl/can_signal_extract_scale.sv */
// Motorola-order CAN signal decoder with Q16.16 scaling and Q32.16 limits.
// Input channel i_in (csx_in_if sink): eight payload bytes plus one signal
// definition per word. Output channel o_out (csx_out_if source): the scaled,
// clamped value in Q48.16 and a range error flag. A word moves on a rising
// edge of i_clk with valid and ready both high.
// Pipeline: extract and sign-extend, multiply, add offset, clamp; four
// register stages, so a result is driven to o_out from the clamp register.
// One word per cycle is accepted and delivered in steady state while
// o_out.ready stays high.
// A field needing a fourth byte or running past byte 7 returns zero with
// range_error set.
// Each stage carries its own valid bit and holds while the stage after it
// is full and stalled; empty stages keep filling, so input ready drops only
// once all four stages hold data. Nothing is dropped or repeated.
// Synchronous active-low i_rst_n clears every stage valid bit; the block
// is ready once reset has cleared them.
module can_signal_extract_scale (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csx_in_if.sink     i_in,
    csx_out_if.source  o_out
);

    csx_pkg::t_req   req;
    csx_pkg::t_raw   raw;
    csx_pkg::t_prod  prod;
    csx_pkg::t_sum   sum;
    csx_pkg::t_res   res;
    logic            raw_valid;
    logic            raw_ready;
    logic            prod_valid;
    logic            prod_ready;
    logic            sum_valid;
    logic            sum_ready;

    always_comb begin
        req.frame_data   = i_in.frame_data;
        req.msb_pos      = i_in.msb_pos;
        req.field_len    = i_in.field_len;
        req.sign_mode    = i_in.sign_mode;
        req.scale_factor = i_in.scale_factor;
        req.phys_offset  = i_in.phys_offset;
        req.lower_limit  = i_in.lower_limit;
        req.upper_limit  = i_in.upper_limit;
    end

    csx_extract u_extract (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_req   (req),
        .o_valid (raw_valid),
        .i_ready (raw_ready),
        .o_raw   (raw)
    );

    csx_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (raw_valid),
        .o_ready (raw_ready),
        .i_raw   (raw),
        .o_valid (prod_valid),
        .i_ready (prod_ready),
        .o_prod  (prod)
    );

    csx_add u_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_valid),
        .o_ready (prod_ready),
        .i_prod  (prod),
        .o_valid (sum_valid),
        .i_ready (sum_ready),
        .o_sum   (sum)
    );

    csx_clamp u_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sum_valid),
        .o_ready (sum_ready),
        .i_sum   (sum),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (res)
    );

    assign o_out.phys_value  = res.phys_value;
    assign o_out.range_error = res.range_error;

endmodule
